// ===== sv/lcd4_pkg.sv =====
// Shared types, codes and sequencing tables for the 4-bit LCD sequencer.
package lcd4_pkg;

	// Request function codes
	localparam logic [2:0] FUNC_DATA    = 3'd0;
	localparam logic [2:0] FUNC_CMD     = 3'd1;
	localparam logic [2:0] FUNC_INIT    = 3'd2;
	localparam logic [2:0] FUNC_CLEAR   = 3'd3;
	localparam logic [2:0] FUNC_DISP_ON = 3'd4;
	localparam logic [2:0] FUNC_CURSOR  = 3'd5;

	// Command bytes
	localparam logic [7:0] CMD_CLEAR     = 8'h01;
	localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
	localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

	// Nibble phases: enable low, enable high, enable low with settle time
	localparam logic [1:0] PH_SETUP  = 2'd0;
	localparam logic [1:0] PH_STROBE = 2'd1;
	localparam logic [1:0] PH_SETTLE = 2'd2;

	// Hold times in microseconds
	localparam logic [15:0] HOLD_PULSE    = 16'd2;
	localparam logic [15:0] HOLD_SETTLE   = 16'd100;
	localparam logic [15:0] HOLD_POWER_UP = 16'd50000;
	localparam logic [15:0] WAIT_WAKE_1   = 16'd4500;
	localparam logic [15:0] WAIT_WAKE_3   = 16'd150;
	localparam logic [15:0] WAIT_CLEAR    = 16'd2000;

	// Last nibble index of each job kind
	localparam logic [3:0] BYTE_LAST_NIB = 4'd1;
	localparam logic [3:0] INIT_LAST_NIB = 4'd11;

	// One queued job for the back end
	typedef struct packed {
		logic       init;   // full power-up sequence
		logic       rs;     // register select for a byte job
		logic       clear;  // byte is clear, long wait after low nibble
		logic [7:0] value;  // byte for a byte job
	} job_t;

	// Nibble n of the init sequence: wake-up then four commands
	function automatic logic [3:0] init_nibble(input logic [3:0] n, input logic two_line);
		logic [3:0] nib;
		begin
			case (n)
				4'd0, 4'd1, 4'd2: nib = 4'h3;
				4'd3, 4'd4:       nib = 4'h2;
				4'd5:             nib = two_line ? 4'h8 : 4'h0;
				4'd6:             nib = 4'h0;
				4'd7:             nib = 4'hC;
				4'd8:             nib = 4'h0;
				4'd9:             nib = 4'h1;
				4'd10:            nib = 4'h0;
				4'd11:            nib = 4'h6;
				default:          nib = 4'h0;
			endcase
			return nib;
		end
	endfunction

	// Extra wait after the settle action of nibble n
	function automatic logic [15:0] extra_wait(input job_t job, input logic [3:0] n);
		logic [15:0] w;
		begin
			w = 16'd0;
			if (job.init) begin
				case (n)
					4'd0, 4'd1: w = WAIT_WAKE_1;
					4'd2:       w = WAIT_WAKE_3;
					4'd9:       w = WAIT_CLEAR;
					default:    w = 16'd0;
				endcase
			end else if (job.clear && n == BYTE_LAST_NIB) begin
				w = WAIT_CLEAR;
			end
			return w;
		end
	endfunction

endpackage

// ===== sv/lcd4_front.sv =====
// Front end: classifies a request into a queued job, computes cursor address.
module lcd4_front import lcd4_pkg::*; (
	input  logic [2:0] func,
	input  logic [7:0] byte_value,
	input  logic [7:0] cursor_col,
	input  logic [7:0] cursor_row,
	input  logic [2:0] line_count,
	output logic       job_valid,
	output job_t       job
);

	logic [2:0] lines;
	logic [7:0] col_m1;
	logic [7:0] row_m1;
	logic [1:0] row_sel;
	logic [7:0] row_base;
	logic [7:0] addr;

	// Clamp line count to 1..4, then clamp the zero-based row
	always_comb begin
		if (line_count == 3'd0)
			lines = 3'd1;
		else if (line_count > 3'd4)
			lines = 3'd4;
		else
			lines = line_count;
		col_m1 = cursor_col - 8'd1;
		row_m1 = cursor_row - 8'd1;
		if (row_m1 >= {5'd0, lines})
			row_sel = 2'(lines - 3'd1);
		else
			row_sel = row_m1[1:0];
		case (row_sel)
			2'd0:    row_base = 8'h00;
			2'd1:    row_base = 8'h40;
			2'd2:    row_base = 8'h14;
			default: row_base = 8'h54;
		endcase
		addr = CMD_SET_DDRAM | (col_m1 + row_base);
	end

	// Classify request
	always_comb begin
		job_valid = 1'b1;
		job       = '0;
		case (func)
			FUNC_DATA: begin
				job.rs    = 1'b1;
				job.value = byte_value;
			end
			FUNC_CMD: begin
				job.value = byte_value;
			end
			FUNC_INIT: begin
				job.init = 1'b1;
			end
			FUNC_CLEAR: begin
				job.clear = 1'b1;
				job.value = CMD_CLEAR;
			end
			FUNC_DISP_ON: begin
				job.value = CMD_DISP_ON;
			end
			FUNC_CURSOR: begin
				job.value = addr;
			end
			default: begin
				// unused codes produce nothing
				job_valid = 1'b0;
			end
		endcase
	end

endmodule

// ===== sv/lcd4_queue.sv =====
// Two-entry job queue between front and back end.
module lcd4_queue import lcd4_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head_job
);

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_job   = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

endmodule

// ===== sv/lcd4_back.sv =====
// Back end: expands the head job into timed pin actions, one per cycle while out_ready is high.
module lcd4_back import lcd4_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  job_t        head_job,
	input  logic [2:0]  line_count,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        reg_select,
	output logic        enable_level,
	output logic [3:0]  bus_nibble,
	output logic [15:0] hold_us,
	output logic        last
);

	logic [3:0] nib_idx_q;
	logic [1:0] phase_q;
	logic       prologue_done_q;
	logic [3:0] held_q;
	logic       out_valid_q;

	logic        load;
	logic        in_prologue;
	logic [3:0]  nib;
	logic [3:0]  last_nib;
	logic        act_rs;
	logic        act_en;
	logic [3:0]  act_nib;
	logic [15:0] act_hold;
	logic        act_last;

	assign load        = head_valid && (!out_valid_q || out_ready);
	assign pop         = load && act_last;
	assign out_valid   = out_valid_q;
	assign in_prologue = head_job.init && !prologue_done_q;

	// Next action from the head job and the position within it
	always_comb begin
		last_nib = head_job.init ? INIT_LAST_NIB : BYTE_LAST_NIB;
		if (head_job.init)
			nib = init_nibble(nib_idx_q, line_count > 3'd1);
		else if (nib_idx_q == 4'd0)
			nib = head_job.value[7:4];
		else
			nib = head_job.value[3:0];
		if (in_prologue) begin
			act_rs   = 1'b0;
			act_en   = 1'b0;
			act_nib  = held_q;
			act_hold = HOLD_POWER_UP;
			act_last = 1'b0;
		end else begin
			act_rs   = head_job.init ? 1'b0 : head_job.rs;
			act_en   = (phase_q == PH_STROBE);
			act_nib  = nib;
			act_hold = (phase_q == PH_SETTLE) ?
				HOLD_SETTLE + extra_wait(head_job, nib_idx_q) : HOLD_PULSE;
			act_last = (phase_q == PH_SETTLE) && (nib_idx_q == last_nib);
		end
	end

	// Sequencer position and held bus nibble
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nib_idx_q       <= 4'd0;
			phase_q         <= PH_SETUP;
			prologue_done_q <= 1'b0;
			held_q          <= 4'd0;
			out_valid_q     <= 1'b0;
		end else begin
			if (out_ready || !out_valid_q)
				out_valid_q <= head_valid;
			if (load) begin
				if (in_prologue) begin
					prologue_done_q <= 1'b1;
				end else begin
					held_q <= nib;
					if (act_last) begin
						nib_idx_q       <= 4'd0;
						phase_q         <= PH_SETUP;
						prologue_done_q <= 1'b0;
					end else if (phase_q == PH_SETTLE) begin
						nib_idx_q <= nib_idx_q + 4'd1;
						phase_q   <= PH_SETUP;
					end else begin
						phase_q <= phase_q + 2'd1;
					end
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (load) begin
			reg_select   <= act_rs;
			enable_level <= act_en;
			bus_nibble   <= act_nib;
			hold_us      <= act_hold;
			last         <= act_last;
		end
	end

endmodule

// ===== sv/char_lcd_4bit_interface_sequencer_core.sv =====
// Top level of the 4-bit character LCD sequencer: front end, job queue, back end.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------------
//   request  | in_valid / in_ready    | func, byte_value, cursor_col, cursor_row
//   action   | out_valid / out_ready  | reg_select, enable_level, bus_nibble, hold_us, last
//   config   | cfg_write_en           | cfg_write_data (line count)
//
// A byte request gives six actions; initialization gives 37. The back end emits one action
// per cycle while out_ready is high, so its action count per request sets the rate.
// The queue holds the request in progress plus one waiting request; a third waits at in_ready.
// out_ready low freezes the back end while out_valid is high; a job is queued before its
// first action is registered. Unused function codes are accepted and give no action.
// Reset clears the queue, the sequencer position, the held nibble and sets line count 1.
module char_lcd_4bit_interface_sequencer_core import lcd4_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [2:0]  cfg_write_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [7:0]  byte_value,
	input  logic [7:0]  cursor_col,
	input  logic [7:0]  cursor_row,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        reg_select,
	output logic        enable_level,
	output logic [3:0]  bus_nibble,
	output logic [15:0] hold_us,
	output logic        last
);

	logic [2:0] line_count_q;
	logic       job_valid;
	job_t       job;
	logic       full;
	logic       head_valid;
	job_t       head_job;
	logic       pop;

	// Line count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			line_count_q <= 3'd1;
		else if (cfg_write_en)
			line_count_q <= cfg_write_data;
	end

	assign in_ready = !full;

	lcd4_front u_front (
		.func       (func),
		.byte_value (byte_value),
		.cursor_col (cursor_col),
		.cursor_row (cursor_row),
		.line_count (line_count_q),
		.job_valid  (job_valid),
		.job        (job)
	);

	lcd4_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_valid && !full && job_valid),
		.push_job   (job),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	lcd4_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_job     (head_job),
		.line_count   (line_count_q),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.reg_select   (reg_select),
		.enable_level (enable_level),
		.bus_nibble   (bus_nibble),
		.hold_us      (hold_us),
		.last         (last)
	);

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the 4-bit character LCD sequencer core with an action scoreboard.
import lcd4_pkg::*;

// Codes the package does not name
localparam logic [2:0] FUNC_UNUSED_6  = 3'd6;
localparam logic [2:0] FUNC_UNUSED_7  = 3'd7;
localparam logic [7:0] CMD_FSET_1LINE = 8'h20;
localparam logic [7:0] CMD_FSET_2LINE = 8'h28;
localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
localparam logic [3:0] NIB_WAKE       = 4'h3;
localparam logic [3:0] NIB_4BIT       = 4'h2;

typedef struct packed {
	logic [2:0] func;
	logic [7:0] value;
	logic [7:0] col;
	logic [7:0] row;
} lcd_request_t;

typedef struct packed {
	logic        rs;
	logic        en;
	logic [3:0]  nib;
	logic [15:0] hold;
	logic        is_last;
} lcd_action_t;

// Predicts the pin actions of each request and checks them in order
class lcd_action_scoreboard;
	lcd_action_t expected_actions[$];
	logic [2:0]  line_count;
	logic [3:0]  held_nibble;
	logic        display_on;
	logic [7:0]  row_base [4];
	int          errors;

	function new();
		line_count  = 3'd1;
		held_nibble = 4'h0;
		display_on  = 1'b0;
		errors      = 0;
		row_base    = '{8'h00, 8'h40, 8'h14, 8'h54};
	endfunction

	function int pending();
		return expected_actions.size();
	endfunction

	function void push_action(logic rs, logic en, logic [3:0] nib, logic [15:0] hold);
		lcd_action_t act;
		act.rs      = rs;
		act.en      = en;
		act.nib     = nib;
		act.hold    = hold;
		act.is_last = 1'b0;
		expected_actions.push_back(act);
	endfunction

	// Setup, strobe, settle; any extra wait rides on the settle action
	function void push_nibble(logic rs, logic [3:0] nib, logic [15:0] extra);
		held_nibble = nib;
		push_action(rs, 1'b0, nib, HOLD_PULSE);
		push_action(rs, 1'b1, nib, HOLD_PULSE);
		push_action(rs, 1'b0, nib, HOLD_SETTLE + extra);
	endfunction

	function void push_byte(logic rs, logic [7:0] value, logic [15:0] extra);
		push_nibble(rs, value[7:4], 16'd0);
		push_nibble(rs, value[3:0], extra);
	endfunction

	function void note_request(lcd_request_t req);
		int         n_prior;
		logic [2:0] lines;
		logic [7:0] col_m1;
		logic [7:0] row_m1;
		n_prior = expected_actions.size();
		case (req.func)
			FUNC_DATA: push_byte(1'b1, req.value, 16'd0);
			FUNC_CMD:  push_byte(1'b0, req.value, 16'd0);
			FUNC_INIT: begin
				// power-up wait keeps whatever nibble is on the bus
				push_action(1'b0, 1'b0, held_nibble, HOLD_POWER_UP);
				push_nibble(1'b0, NIB_WAKE, WAIT_WAKE_1);
				push_nibble(1'b0, NIB_WAKE, WAIT_WAKE_1);
				push_nibble(1'b0, NIB_WAKE, WAIT_WAKE_3);
				push_nibble(1'b0, NIB_4BIT, 16'd0);
				push_byte(1'b0, (line_count > 3'd1) ? CMD_FSET_2LINE : CMD_FSET_1LINE, 16'd0);
				display_on = 1'b1;
				push_byte(1'b0, CMD_DISP_ON, 16'd0);
				push_byte(1'b0, CMD_CLEAR, WAIT_CLEAR);
				push_byte(1'b0, CMD_ENTRY_MODE, 16'd0);
			end
			FUNC_CLEAR: push_byte(1'b0, CMD_CLEAR, WAIT_CLEAR);
			FUNC_DISP_ON: begin
				display_on = 1'b1;
				push_byte(1'b0, CMD_DISP_ON, 16'd0);
			end
			FUNC_CURSOR: begin
				// line count of 0 acts as 1, above 4 acts as 4
				lines = line_count;
				if (lines < 3'd1)
					lines = 3'd1;
				if (lines > 3'd4)
					lines = 3'd4;
				col_m1 = req.col - 8'd1;
				row_m1 = req.row - 8'd1;
				if (row_m1 >= {5'd0, lines})
					row_m1 = {5'd0, lines} - 8'd1;
				push_byte(1'b0, CMD_SET_DDRAM | (col_m1 + row_base[row_m1[1:0]]), 16'd0);
			end
			default: ;
		endcase
		if (expected_actions.size() > n_prior)
			expected_actions[expected_actions.size() - 1].is_last = 1'b1;
	endfunction

	function void check_action(lcd_action_t got);
		lcd_action_t want;
		if (expected_actions.size() == 0) begin
			$error("unexpected action: rs %0d en %0d nibble %h hold %0d last %0d",
				got.rs, got.en, got.nib, got.hold, got.is_last);
			errors++;
			return;
		end
		want = expected_actions.pop_front();
		if (got.rs !== want.rs) begin
			$error("reg_select: expected %0d, got %0d", want.rs, got.rs);
			errors++;
		end
		if (got.en !== want.en) begin
			$error("enable_level: expected %0d, got %0d", want.en, got.en);
			errors++;
		end
		if (got.nib !== want.nib) begin
			$error("bus_nibble: expected %h, got %h", want.nib, got.nib);
			errors++;
		end
		if (got.hold !== want.hold) begin
			$error("hold_us: expected %0d, got %0d", want.hold, got.hold);
			errors++;
		end
		if (got.is_last !== want.is_last) begin
			$error("last: expected %0d, got %0d", want.is_last, got.is_last);
			errors++;
		end
	endfunction
endclass

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT      = 1_000_000;
	localparam int SETTLE_CYCLES    = 20;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS      = 24;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_write_en;
	logic [2:0]  cfg_write_data;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  func;
	logic [7:0]  byte_value;
	logic [7:0]  cursor_col;
	logic [7:0]  cursor_row;
	logic        out_valid;
	logic        out_ready;
	logic        reg_select;
	logic        enable_level;
	logic [3:0]  bus_nibble;
	logic [15:0] hold_us;
	logic        last;

	lcd_action_scoreboard action_sb;
	bit long_hold_go   = 1'b0;
	bit long_hold_done = 1'b0;
	int cycle_count    = 0;

	char_lcd_4bit_interface_sequencer_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.byte_value     (byte_value),
		.cursor_col     (cursor_col),
		.cursor_row     (cursor_row),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.reg_select     (reg_select),
		.enable_level   (enable_level),
		.bus_nibble     (bus_nibble),
		.hold_us        (hold_us),
		.last           (last)
	);

	always #10 clk = ~clk;

	// Mostly no gap, some short, a few long
	function automatic int idle_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 25);
	endfunction

	// Well-formed requests dominate; unused codes and odd rows mixed in
	function automatic lcd_request_t random_request();
		lcd_request_t req;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 28)
			req.func = FUNC_DATA;
		else if (pick < 48)
			req.func = FUNC_CMD;
		else if (pick < 52)
			req.func = FUNC_INIT;
		else if (pick < 60)
			req.func = FUNC_CLEAR;
		else if (pick < 67)
			req.func = FUNC_DISP_ON;
		else if (pick < 95)
			req.func = FUNC_CURSOR;
		else
			req.func = (pick % 2 != 0) ? FUNC_UNUSED_7 : FUNC_UNUSED_6;
		req.value = 8'($urandom);
		req.col   = 8'($urandom);
		req.row   = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 5)) : 8'($urandom);
		return req;
	endfunction

	// Offer one request, hold it until taken, then maybe go idle
	task automatic issue(input lcd_request_t req, input bit steady);
		int gap;
		in_valid   <= 1'b1;
		func       <= req.func;
		byte_value <= req.value;
		cursor_col <= req.col;
		cursor_row <= req.row;
		do
			@(posedge clk);
		while (!in_ready);
		action_sb.note_request(req);
		gap = steady ? 0 : idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and let every predicted action come out
	task automatic drain_actions();
		in_valid <= 1'b0;
		while (action_sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_lines(input logic [2:0] value);
		drain_actions();
		cfg_write_en   <= 1'b1;
		cfg_write_data <= value;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		action_sb.line_count = value;
	endtask

	// Sink wait that cuts short when the long hold is requested
	task automatic sink_wait(input int n);
		for (int k = 0; k < n; k++) begin
			@(posedge clk);
			if (long_hold_go && !long_hold_done)
				break;
		end
	endtask

	// Request source
	initial begin : request_source
		lcd_request_t directed_reqs [15];
		logic [2:0]   lines_plan [8];
		lcd_request_t req;
		bit           steady;
		action_sb = new();
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		func           <= FUNC_DATA;
		byte_value     <= 8'h00;
		cursor_col     <= 8'h00;
		cursor_row     <= 8'h00;
		cfg_write_en   <= 1'b0;
		cfg_write_data <= 3'd0;
		directed_reqs = '{
			'{FUNC_INIT,     8'h00, 8'h00, 8'h00},
			'{FUNC_DATA,     8'h00, 8'h00, 8'h00},
			'{FUNC_DATA,     8'hFF, 8'hFF, 8'hFF},
			'{FUNC_CMD,      8'h5A, 8'h00, 8'h00},
			'{FUNC_CMD,      8'hA5, 8'h00, 8'h00},
			'{FUNC_CLEAR,    8'h00, 8'h00, 8'h00},
			'{FUNC_DISP_ON,  8'h00, 8'h00, 8'h00},
			'{FUNC_CURSOR,   8'h00, 8'h01, 8'h01},
			'{FUNC_CURSOR,   8'h00, 8'h00, 8'h00},
			'{FUNC_CURSOR,   8'hFF, 8'hFF, 8'hFF},
			'{FUNC_CURSOR,   8'h00, 8'h10, 8'h02},
			'{FUNC_UNUSED_6, 8'hFF, 8'hFF, 8'hFF},
			'{FUNC_UNUSED_7, 8'h00, 8'h00, 8'h00},
			'{FUNC_DATA,     8'h3C, 8'h00, 8'h00},
			'{FUNC_INIT,     8'h00, 8'h00, 8'h00}
		};
		lines_plan = '{3'd2, 3'd0, 3'd7, 3'd4, 3'd1, 3'd3, 3'd5, 3'd6};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pass at the reset line count
		foreach (directed_reqs[i])
			issue(directed_reqs[i], (i % 2) == 0);

		// random phases, one per line count setting, each opened by an init
		foreach (lines_plan[p]) begin
			write_lines(lines_plan[p]);
			steady = (p % 3) == 2;
			req = '0;
			req.func = FUNC_INIT;
			issue(req, steady);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 1 && n == 2)
					long_hold_go = 1'b1;
				issue(random_request(), steady);
			end
		end

		drain_actions();
		if (action_sb.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Action sink: random stalls, steady stretches, one long hold
	initial begin : action_sink
		int stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (long_hold_go && !long_hold_done) begin
				out_ready <= 1'b0;
				long_hold_done = 1'b1;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else if ($urandom_range(0, 9) == 0) begin
				out_ready <= 1'b1;
				sink_wait($urandom_range(40, 120));
			end else begin
				stall = idle_gap();
				if (stall > 0) begin
					out_ready <= 1'b0;
					sink_wait(stall);
				end else begin
					out_ready <= 1'b1;
					sink_wait($urandom_range(1, 6));
				end
			end
		end
	end

	// Check every accepted action
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			action_sb.check_action(lcd_action_t'{reg_select, enable_level, bus_nibble,
				hold_us, last});
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end
endmodule

// ===== files.f =====
sv/lcd4_pkg.sv
sv/lcd4_front.sv
sv/lcd4_queue.sv
sv/lcd4_back.sv
sv/char_lcd_4bit_interface_sequencer_core.sv
tb/tb_top.sv
